// File: hw/rtl/ece_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ece_pkg
// Shared types, constants and the quarter-wave sine table of the easing
// curve evaluator.
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int FRAC_BITS        = 15;

  // payload widths of the channels
  localparam int SEL_W  = 3;
  localparam int PROG_W = 16;
  localparam int EV_W   = 16;

  // internal value range is 0 .. ONE inclusive
  localparam int VAL_W  = FRAC_BITS + 1;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int POS_W  = VAL_W + IDX_W;
  // bounce argument reaches 22 * ONE
  localparam int U_W    = FRAC_BITS + 5;
  localparam int PROD_W = 2 * U_W;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRAC_BITS);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // bounce segment bounds on s = 22 * t, and their centers c * ONE
  localparam logic [U_W-1:0] BND_1 = U_W'(8 << FRAC_BITS);
  localparam logic [U_W-1:0] BND_2 = U_W'(16 << FRAC_BITS);
  localparam logic [U_W-1:0] BND_3 = U_W'(20 << FRAC_BITS);
  localparam logic [U_W-1:0] CTR_1 = U_W'(12 << FRAC_BITS);
  localparam logic [U_W-1:0] CTR_2 = U_W'(18 << FRAC_BITS);
  localparam logic [U_W-1:0] CTR_3 = U_W'(21 << FRAC_BITS);
  localparam logic [VAL_W-1:0] OFF_1 = VAL_W'((3 << FRAC_BITS) >> 2);
  localparam logic [VAL_W-1:0] OFF_2 = VAL_W'((15 << FRAC_BITS) >> 4);
  localparam logic [VAL_W-1:0] OFF_3 = VAL_W'((63 << FRAC_BITS) >> 6);

  localparam logic [PROD_W:0] SIN_RND = (PROD_W+1)'(1 << (FRAC_BITS - 1));
  localparam logic [PROD_W:0] BNC_RND = (PROD_W+1)'(1 << (FRAC_BITS + 5));

  typedef enum logic [SEL_W-1:0] {
    CURVE_LINEAR       = 3'd0,
    CURVE_SINE_IN      = 3'd1,
    CURVE_SINE_OUT     = 3'd2,
    CURVE_SINE_INOUT   = 3'd3,
    CURVE_BOUNCE_IN    = 3'd4,
    CURVE_BOUNCE_OUT   = 3'd5,
    CURVE_BOUNCE_INOUT = 3'd6,
    CURVE_NONE         = 3'd7
  } curve_t;

  typedef enum logic [1:0] {
    KIND_LINEAR = 2'd0,
    KIND_SINE   = 2'd1,
    KIND_BOUNCE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    POST_DIRECT     = 2'd0,
    POST_ONE_MINUS  = 2'd1,
    POST_HALF_MINUS = 2'd2,
    POST_HALF_PLUS  = 2'd3
  } post_t;

  // operands handed from the prep logic to the multiply stage
  typedef struct packed {
    logic [U_W-1:0]   mul_a;
    logic [U_W-1:0]   mul_b;
    logic [VAL_W-1:0] base;
    logic             bounce;
  } prep_t;

  typedef logic [VAL_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // entry k is sin(k*pi/(2*depth)), taylor series through x^13 in q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (sum > 64'(ONE)) begin
        sum = 64'(ONE);
      end
      rom[k] = sum[VAL_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

// File: hw/rtl/ece_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ece_channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface ece_req_if;
  import ece_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEL_W-1:0]  req_type;
  logic [PROG_W-1:0] progress;

  modport source (output valid, output req_type, output progress, input ready);
  modport sink   (input valid, input req_type, input progress, output ready);
endinterface

interface ece_res_if;
  import ece_pkg::*;
  logic            valid;
  logic            ready;
  logic [EV_W-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/easing_curve_evaluator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// easing_curve_evaluator_unit
// Evaluates linear, sine and bounce easing curves on a Q1.15 progress value.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a curve selector (req_type) and progress in unsigned Q1.15;
//   progress above 1.0 is treated as 1.0. res returns eased_value in the
//   same format, one result per request, in request order. Selector 7 (none)
//   returns 0.
//   The datapath is a five stage pipeline: argument fold, table lookup or
//   bounce segment pick, one shared multiply, rounding and offset add, and
//   the final in-out fold in the output register. One transaction is accepted
//   every cycle while the pipe is not held.
//   All stages advance together; when res.ready is low with a result
//   waiting, the whole pipe holds and req.ready drops, so nothing is lost or
//   repeated. Empty stages behind a stalled result hold as well.
//   Reset clears all stage valid bits; no state lives between transactions.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_unit import ece_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ece_req_if.sink   req,
  ece_res_if.source res
);

  logic adv;

  // stage 1: folded argument
  logic             v1;
  kind_t            kind1;
  post_t            post1;
  logic [VAL_W-1:0] arg1;
  kind_t            kind_next;
  post_t            post_next;
  logic [VAL_W-1:0] arg_next;
  logic [VAL_W-1:0] t_sat;
  logic [VAL_W:0]   two_t;

  // stage 2: operands
  logic  v2;
  post_t post2;
  prep_t prep_next;
  prep_t prep2;

  // stage 3: product
  logic              v3;
  post_t             post3;
  logic [PROD_W-1:0] prod3;
  logic [VAL_W-1:0]  base3;
  logic              bounce3;

  // stage 4: curve value
  logic             v4;
  post_t            post4;
  logic [VAL_W-1:0] val4;
  logic [PROD_W:0]  rnd;
  logic [PROD_W:0]  shifted;
  logic [VAL_W:0]   val_sum;
  logic [VAL_W-1:0] val_next;

  // stage 5: output register
  logic             v5;
  logic [VAL_W-1:0] res5;
  logic [VAL_W:0]   fold;
  logic [VAL_W-1:0] res_next;

  assign adv       = !v5 || res.ready;
  assign req.ready = adv;

  assign t_sat = (req.progress > PROG_W'(ONE)) ? ONE : req.progress[VAL_W-1:0];
  assign two_t = {t_sat, 1'b0};

  always_comb begin
    kind_next = KIND_NONE;
    post_next = POST_DIRECT;
    arg_next  = '0;
    case (curve_t'(req.req_type))
      CURVE_LINEAR: begin
        kind_next = KIND_LINEAR;
        arg_next  = t_sat;
      end
      CURVE_SINE_IN: begin
        kind_next = KIND_SINE;
        post_next = POST_ONE_MINUS;
        arg_next  = ONE - t_sat;
      end
      CURVE_SINE_OUT: begin
        kind_next = KIND_SINE;
        arg_next  = t_sat;
      end
      CURVE_SINE_INOUT: begin
        kind_next = KIND_SINE;
        if (two_t <= {1'b0, ONE}) begin
          post_next = POST_HALF_MINUS;
          arg_next  = VAL_W'({1'b0, ONE} - two_t);
        end else begin
          post_next = POST_HALF_PLUS;
          arg_next  = VAL_W'(two_t - {1'b0, ONE});
        end
      end
      CURVE_BOUNCE_IN: begin
        kind_next = KIND_BOUNCE;
        post_next = POST_ONE_MINUS;
        arg_next  = ONE - t_sat;
      end
      CURVE_BOUNCE_OUT: begin
        kind_next = KIND_BOUNCE;
        arg_next  = t_sat;
      end
      CURVE_BOUNCE_INOUT: begin
        kind_next = KIND_BOUNCE;
        if (two_t < {1'b0, ONE}) begin
          post_next = POST_HALF_MINUS;
          arg_next  = VAL_W'({1'b0, ONE} - two_t);
        end else begin
          post_next = POST_HALF_PLUS;
          arg_next  = VAL_W'(two_t - {1'b0, ONE});
        end
      end
      default: begin
        kind_next = KIND_NONE;
        post_next = POST_DIRECT;
        arg_next  = '0;
      end
    endcase
  end

  ece_operand_prep u_prep (
    .kind (kind1),
    .arg  (arg1),
    .prep (prep_next)
  );

  // round and add the base; the value is capped at one
  always_comb begin
    if (bounce3) begin
      rnd     = {1'b0, prod3} + BNC_RND;
      shifted = rnd >> (FRAC_BITS + 6);
    end else begin
      rnd     = {1'b0, prod3} + SIN_RND;
      shifted = rnd >> FRAC_BITS;
    end
    val_sum  = shifted[VAL_W:0] + {1'b0, base3};
    val_next = (val_sum > {1'b0, ONE}) ? ONE : val_sum[VAL_W-1:0];
  end

  always_comb begin
    case (post4)
      POST_DIRECT:     fold = {1'b0, val4};
      POST_ONE_MINUS:  fold = {1'b0, ONE - val4};
      POST_HALF_MINUS: fold = ({1'b0, ONE - val4} + (VAL_W+1)'(1)) >> 1;
      POST_HALF_PLUS:  fold = ({1'b0, ONE} + {1'b0, val4} + (VAL_W+1)'(1)) >> 1;
      default:         fold = {1'b0, val4};
    endcase
    res_next = (fold > {1'b0, ONE}) ? ONE : fold[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1   <= kind_next;
      post1   <= post_next;
      arg1    <= arg_next;
      post2   <= post1;
      prep2   <= prep_next;
      post3   <= post2;
      prod3   <= prep2.mul_a * prep2.mul_b;
      base3   <= prep2.base;
      bounce3 <= prep2.bounce;
      post4   <= post3;
      val4    <= val_next;
      res5    <= res_next;
    end
  end

  assign res.valid       = v5;
  assign res.eased_value = EV_W'(res5);

endmodule
`default_nettype wire

// File: hw/rtl/ece_operand_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ece_operand_prep
// Turns a curve argument into multiplier operands and a base value: table
// lookup and interpolation step for sine, segment pick for bounce.
// ----------------------------------------------------------------------------
module ece_operand_prep import ece_pkg::*; (
  input  kind_t            kind,
  input  logic [VAL_W-1:0] arg,
  output prep_t            prep
);

  logic [POS_W-1:0]     pos;
  logic [IDX_W-1:0]     idx;
  logic [FRAC_BITS-1:0] frac;
  logic [VAL_W-1:0]     rom_a;
  logic [VAL_W-1:0]     rom_b;
  logic [U_W-1:0]       s;
  logic [U_W-1:0]       ctr;
  logic [VAL_W-1:0]     off;
  logic [U_W-1:0]       u;

  assign pos  = POS_W'(arg) * POS_W'(SINE_TABLE_DEPTH);
  assign idx  = pos[FRAC_BITS +: IDX_W];
  assign frac = pos[FRAC_BITS-1:0];

  always_comb begin
    if (idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
      rom_a = SINE_ROM[SINE_TABLE_DEPTH];
      rom_b = SINE_ROM[SINE_TABLE_DEPTH];
    end else begin
      rom_a = SINE_ROM[idx];
      rom_b = SINE_ROM[idx + IDX_W'(1)];
    end
  end

  // bounce segments on s = 22 * t
  assign s = U_W'(arg) * U_W'(22);

  always_comb begin
    if (s < BND_1) begin
      ctr = '0;
      off = '0;
    end else if (s < BND_2) begin
      ctr = CTR_1;
      off = OFF_1;
    end else if (s < BND_3) begin
      ctr = CTR_2;
      off = OFF_2;
    end else begin
      ctr = CTR_3;
      off = OFF_3;
    end
    u = (s >= ctr) ? (s - ctr) : (ctr - s);
  end

  always_comb begin
    prep = '0;
    case (kind)
      KIND_LINEAR: begin
        prep.base = arg;
      end
      KIND_SINE: begin
        prep.base  = rom_a;
        prep.mul_a = (rom_b > rom_a) ? U_W'(rom_b - rom_a) : '0;
        prep.mul_b = U_W'(frac);
      end
      KIND_BOUNCE: begin
        prep.base   = off;
        prep.mul_a  = u;
        prep.mul_b  = u;
        prep.bounce = 1'b1;
      end
      default: begin
        prep = '0;
      end
    endcase
  end

endmodule
`default_nettype wire
